// ===== sv/vn2o_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package vn2o_pkg;

  // widths of the stream and configuration payloads
  localparam int COORD_W    = 32;
  localparam int NOISE_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // internal widths
  localparam int FREQ_W = 32;
  localparam int AMP_W  = 20;
  localparam int W_W    = 20;
  localparam int TERM_W = 36;
  localparam int ACC_W  = 40;

  // default number of octave lanes
  localparam int MAX_OCTAVES_DEF = 8;

  // register stages inside one octave lane
  localparam int LANE_LAT = 10;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERSISTENCE = 3'd0,
    CFG_OCTAVE_CNT  = 3'd1,
    CFG_BASE_FREQ   = 3'd2,
    CFG_BASE_AMP    = 3'd3,
    CFG_DOUBLE_FREQ = 3'd4,
    CFG_SCALE_AMP   = 3'd5
  } cfg_idx_e;

  // reset values of the registers
  localparam logic [15:0]         RST_PERSISTENCE = 16'd16384;
  localparam logic [3:0]          RST_OCTAVE_CNT  = 4'd4;
  localparam logic [23:0]         RST_BASE_FREQ   = 24'd983;
  localparam logic [AMP_W-1:0]    RST_BASE_AMP    = 20'd65536;

  // lattice hash constants
  localparam logic [31:0] HASH_MUL_Y = 32'd57;
  localparam int          HASH_SHIFT = 13;
  localparam logic [31:0] HASH_C1    = 32'd15731;
  localparam logic [31:0] HASH_C2    = 32'd789221;
  localparam logic [31:0] HASH_C3    = 32'd1376312589;
  localparam logic signed [31:0] LAT_ONE = 32'sd1073741824;

  // integer part and signed fraction of a scaled coordinate
  typedef struct packed {
    logic [31:0]        ipart;
    logic signed [16:0] frac;
  } split_t;

  function automatic split_t split_coord(input logic signed [63:0] p);
    logic        neg;
    logic [63:0] mag;
    split_t      r;
    neg     = p[63];
    mag     = neg ? 64'(-p) : 64'(p);
    r.ipart = neg ? (32'd0 - mag[63:32]) : mag[63:32];
    r.frac  = neg ? (17'sd0 - $signed({1'b0, mag[31:16]}))
                  : $signed({1'b0, mag[31:16]});
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/vn2o_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// coordinate stream
interface vn2o_coord_if;
  import vn2o_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [COORD_W-1:0]  x_coord;
  logic signed [COORD_W-1:0]  y_coord;
  modport source (output valid, x_coord, y_coord, input ready);
  modport sink   (input valid, x_coord, y_coord, output ready);
endinterface

// noise result stream
interface vn2o_noise_if;
  import vn2o_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [NOISE_W-1:0]  noise_value;
  modport source (output valid, noise_value, input ready);
  modport sink   (input valid, noise_value, output ready);
endinterface

// configuration write channel
interface vn2o_cfg_if;
  import vn2o_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_IDX_W-1:0]   index;
  logic [CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== sv/vn2o_octave.sv =====
`timescale 1ns / 1ps
`default_nettype none
module vn2o_octave (
  input  wire logic                                clk,
  input  wire logic                                en,
  input  wire logic signed [vn2o_pkg::COORD_W-1:0] x_coord,
  input  wire logic signed [vn2o_pkg::COORD_W-1:0] y_coord,
  input  wire logic [vn2o_pkg::FREQ_W-1:0]         freq,
  input  wire logic [vn2o_pkg::AMP_W-1:0]          amp,
  output logic signed [vn2o_pkg::TERM_W-1:0]       term
);
  import vn2o_pkg::*;

  // stage 1: scale coordinates
  logic signed [63:0] p1 [2];
  always_ff @(posedge clk) begin
    if (en) begin
      p1[0] <= x_coord * $signed({32'd0, freq});
      p1[1] <= y_coord * $signed({32'd0, freq});
    end
  end

  // stage 2: integer part and fraction
  split_t s2 [2];
  always_ff @(posedge clk) begin
    if (en) begin
      s2[0] <= split_coord(p1[0]);
      s2[1] <= split_coord(p1[1]);
    end
  end

  // stage 3: lattice grid hash seeds and fraction squares
  logic [31:0]        gx [4];
  logic [31:0]        gy [4];
  logic [31:0]        n3_next [4][4];
  logic [31:0]        n3 [4][4];
  logic signed [33:0] f2_3 [2];
  logic signed [16:0] f_3 [2];
  always_comb begin
    for (int a = 0; a < 4; a++) begin
      gx[a] = s2[0].ipart + 32'(a) - 32'd1;
      gy[a] = s2[1].ipart + 32'(a) - 32'd1;
    end
    for (int a = 0; a < 4; a++) begin
      for (int b = 0; b < 4; b++) begin
        n3_next[a][b] = gx[a] + gy[b] * HASH_MUL_Y;
        n3_next[a][b] = n3_next[a][b] ^ (n3_next[a][b] << HASH_SHIFT);
      end
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      n3 <= n3_next;
      for (int d = 0; d < 2; d++) begin
        f2_3[d] <= s2[d].frac * s2[d].frac;
        f_3[d]  <= s2[d].frac;
      end
    end
  end

  // stage 4: hash square, fraction cube
  logic [31:0]        nn4 [4][4];
  logic [31:0]        n4 [4][4];
  logic signed [50:0] f3_4 [2];
  logic signed [33:0] f2_4 [2];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 4; a++) begin
        for (int b = 0; b < 4; b++) begin
          nn4[a][b] <= n3[a][b] * n3[a][b];
        end
      end
      n4 <= n3;
      for (int d = 0; d < 2; d++) begin
        f3_4[d] <= f2_3[d] * f_3[d];
        f2_4[d] <= f2_3[d];
      end
    end
  end

  // stage 5: hash polynomial, smoothstep weights
  logic [31:0]        t5 [4][4];
  logic [31:0]        n5 [4][4];
  logic [W_W-1:0]     w5 [2];
  logic signed [63:0] num [2];
  always_comb begin
    for (int d = 0; d < 2; d++) begin
      num[d] = 64'(f2_4[d]) * 64'sd196608 - 64'(f3_4[d]) * 64'sd2;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 4; a++) begin
        for (int b = 0; b < 4; b++) begin
          t5[a][b] <= nn4[a][b] * HASH_C1 + HASH_C2;
        end
      end
      n5 <= n4;
      for (int d = 0; d < 2; d++) begin
        w5[d] <= num[d][32+W_W-1:32];
      end
    end
  end

  // stage 6: lattice values
  logic signed [31:0] lat6 [4][4];
  logic [31:0]        h6 [4][4];
  logic [W_W-1:0]     w6 [2];
  always_comb begin
    for (int a = 0; a < 4; a++) begin
      for (int b = 0; b < 4; b++) begin
        h6[a][b] = n5[a][b] * t5[a][b] + HASH_C3;
      end
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 4; a++) begin
        for (int b = 0; b < 4; b++) begin
          lat6[a][b] <= LAT_ONE - $signed({1'b0, h6[a][b][30:0]});
        end
      end
      w6 <= w5;
    end
  end

  // stage 7: 3x3 smoothing of the four cell corners
  logic signed [35:0] sm [2][2];
  logic signed [31:0] v7 [2][2];
  logic [W_W-1:0]     w7 [2];
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 2; j++) begin
        sm[i][j] = 36'sd0;
        for (int da = 0; da < 3; da++) begin
          for (int db = 0; db < 3; db++) begin
            sm[i][j] = sm[i][j] + (36'(lat6[i+da][j+db])
                       <<< ((da == 1 ? 1 : 0) + (db == 1 ? 1 : 0)));
          end
        end
      end
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 2; i++) begin
        for (int j = 0; j < 2; j++) begin
          v7[i][j] <= 32'(sm[i][j] >>> 4);
        end
      end
      w7 <= w6;
    end
  end

  // stage 8: blend in x
  logic signed [32:0] dx [2];
  logic signed [53:0] px [2];
  logic signed [39:0] i8 [2];
  logic [W_W-1:0]     wy8;
  always_comb begin
    for (int j = 0; j < 2; j++) begin
      dx[j] = 33'(v7[1][j]) - 33'(v7[0][j]);
      px[j] = 54'(dx[j]) * 54'($signed({1'b0, w7[0]}));
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 2; j++) begin
        i8[j] <= 40'(v7[0][j]) + 40'(px[j] >>> 16);
      end
      wy8 <= w7[1];
    end
  end

  // stage 9: blend in y
  logic signed [40:0] dy;
  logic signed [61:0] py;
  logic signed [47:0] i9;
  always_comb begin
    dy = 41'(i8[1]) - 41'(i8[0]);
    py = 62'(dy) * 62'($signed({1'b0, wy8}));
  end
  always_ff @(posedge clk) begin
    if (en) begin
      i9 <= 48'(i8[0]) + 48'(py >>> 16);
    end
  end

  // stage 10: amplitude weighting
  logic signed [63:0] pa;
  always_comb begin
    pa = 64'(i9) * 64'($signed({1'b0, amp}));
  end
  always_ff @(posedge clk) begin
    if (en) begin
      term <= TERM_W'(pa >>> 30);
    end
  end

endmodule
`default_nettype wire

// ===== sv/value_noise_2d_octaves_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// fractal 2d value noise, one sample per beat
// coord_in carries x_coord / y_coord (signed Q15.16); noise_out returns
// noise_value (signed Q15.16, saturated); cfg writes register index/data.
// every octave has a lane of its own, so a beat can enter on every cycle
// and the throughput is one sample per cycle whatever the octave count,
// as long as the output is not stalled and the tables are not rebuilding.
// an input beat passes 10 lane stages (scale, split, hash seed, three hash
// multiplies, smoothing, two blends, amplitude) and one summing/saturation
// register before output valid. after reset and after every configuration
// write the per-octave frequency and amplitude tables are rebuilt, one
// octave per cycle; coord_in.ready is low during that time.
// the whole pipeline advances only while the output register is empty or
// being taken, so a stalled receiver holds every beat in place.
// reset clears all valid bits and loads the register defaults.
module value_noise_2d_octaves_unit #(
  parameter int MAX_OCTAVES = vn2o_pkg::MAX_OCTAVES_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  vn2o_coord_if.sink     coord_in,
  vn2o_noise_if.source   noise_out,
  vn2o_cfg_if.sink       cfg
);
  import vn2o_pkg::*;

  localparam int IW = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
  localparam int CW = $clog2(MAX_OCTAVES + 1);

  // configuration registers
  logic [15:0]      persistence;
  logic [3:0]       octave_count;
  logic [23:0]      base_frequency;
  logic [AMP_W-1:0] base_amplitude;
  logic             double_freq;
  logic             scale_amp;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      persistence    <= RST_PERSISTENCE;
      octave_count   <= RST_OCTAVE_CNT;
      base_frequency <= RST_BASE_FREQ;
      base_amplitude <= RST_BASE_AMP;
      double_freq    <= 1'b0;
      scale_amp      <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg_idx_e'(cfg.index))
        CFG_PERSISTENCE: persistence    <= cfg.data[15:0];
        CFG_OCTAVE_CNT:  octave_count   <= cfg.data[3:0];
        CFG_BASE_FREQ:   base_frequency <= cfg.data[23:0];
        CFG_BASE_AMP:    base_amplitude <= cfg.data[AMP_W-1:0];
        CFG_DOUBLE_FREQ: double_freq    <= cfg.data[0];
        CFG_SCALE_AMP:   scale_amp      <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // per-octave frequency and amplitude table sequencer
  logic [FREQ_W-1:0] freq_tab [MAX_OCTAVES];
  logic [AMP_W-1:0]  amp_tab  [MAX_OCTAVES];
  logic [FREQ_W-1:0] freq_run, freq_run_next;
  logic [AMP_W-1:0]  amp_run, amp_run_next;
  logic [35:0]       amp_prod;
  logic [CW-1:0]     seq_cnt;
  logic              seq_load;
  logic              busy;

  always_comb begin
    amp_prod = amp_run * persistence;
    if (!double_freq) begin
      freq_run_next = freq_run;
    end else if (freq_run[FREQ_W-1]) begin
      freq_run_next = '1;
    end else begin
      freq_run_next = freq_run << 1;
    end
    amp_run_next = scale_amp ? amp_prod[16+AMP_W-1:16] : amp_run;
  end

  always_ff @(posedge clk) begin
    if (rst || cfg.valid) begin
      seq_load <= 1'b1;
      busy     <= 1'b1;
    end else if (seq_load) begin
      seq_load <= 1'b0;
      seq_cnt  <= '0;
      freq_run <= FREQ_W'(base_frequency);
      amp_run  <= base_amplitude;
    end else if (busy) begin
      freq_tab[seq_cnt[IW-1:0]] <= freq_run_next;
      amp_tab[seq_cnt[IW-1:0]]  <= amp_run_next;
      freq_run <= freq_run_next;
      amp_run  <= amp_run_next;
      seq_cnt  <= seq_cnt + 1'b1;
      if (seq_cnt == CW'(MAX_OCTAVES - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // pipeline advance and input handshake
  logic en;
  logic [LANE_LAT-1:0] vpipe;
  assign en             = !noise_out.valid || noise_out.ready;
  assign coord_in.ready = en && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (en) begin
      vpipe <= {vpipe[LANE_LAT-2:0], coord_in.valid && coord_in.ready};
    end
  end

  // octave lanes
  logic signed [TERM_W-1:0] term [MAX_OCTAVES];
  for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_lane
    vn2o_octave u_octave (
      .clk     (clk),
      .en      (en),
      .x_coord (coord_in.x_coord),
      .y_coord (coord_in.y_coord),
      .freq    (freq_tab[k]),
      .amp     (amp_tab[k]),
      .term    (term[k])
    );
  end

  // octave sum and saturation
  logic signed [ACC_W-1:0]   acc;
  logic signed [NOISE_W-1:0] sat;
  always_comb begin
    acc = '0;
    for (int k = 0; k < MAX_OCTAVES; k++) begin
      if ({1'b0, octave_count} > 5'(k)) begin
        acc = acc + ACC_W'(term[k]);
      end
    end
    if (acc > ACC_W'(64'sd2147483647)) begin
      sat = 32'sh7fffffff;
    end else if (acc < ACC_W'(-64'sd2147483648)) begin
      sat = 32'sh80000000;
    end else begin
      sat = NOISE_W'(acc);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      noise_out.valid <= 1'b0;
    end else if (en) begin
      noise_out.valid <= vpipe[LANE_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      noise_out.noise_value <= sat;
    end
  end

endmodule
`default_nettype wire

// ===== sv/vn2o_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module vn2o_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_value,
  input wire logic        cfg_valid,
  input wire logic        cfg_ready
);

  // a stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // a stalled result beat keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_value))
    else $error("result value changed while stalled");

  // tables are rebuilt after a register write, so no input beat is taken
  a_cfg_busy: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> !in_ready)
    else $error("input taken while tables rebuild");

  // reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind value_noise_2d_octaves_unit vn2o_checker u_vn2o_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (coord_in.ready),
  .out_valid (noise_out.valid),
  .out_ready (noise_out.ready),
  .out_value (noise_out.noise_value),
  .cfg_valid (cfg.valid),
  .cfg_ready (cfg.ready)
);
`default_nettype wire
